// ----- design/bed_pkg.sv -----
package bed_pkg;

  // Default sizing of the mask store and the window
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 7;

  // Field widths
  localparam int POS_W      = 8;   // pos_x / pos_y
  localparam int CFG_DIM_W  = 9;   // image width / height registers
  localparam int CFG_RAD_W  = 3;   // window_radius
  localparam int CFG_IDX_W  = 2;   // configuration register index
  localparam int CFG_DATA_W = 9;   // widest configuration register

  // Window offsets (-7..7) and window coordinates (-7..262)
  localparam int OFS_W   = CFG_RAD_W + 1;
  localparam int COORD_W = CFG_DIM_W + 1;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Filter modes
  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 2'd3;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One window probe, aligned with the store's read data
  typedef struct packed {
    logic valid;
    logic in_frame;
    logic last;
  } probe_t;

endpackage

// ----- design/bed_if.sv -----
// Input item channel
interface bed_in_if import bed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             pixel_in;

  modport source (output valid, command, pos_x, pos_y, pixel_in, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pixel_in, output ready);
endinterface

// Result item channel
interface bed_out_if ();
  logic valid;
  logic ready;
  logic filtered_bit;
  logic coordinate_error;

  modport source (output valid, filtered_bit, coordinate_error, input ready);
  modport sink   (input valid, filtered_bit, coordinate_error, output ready);
endinterface

// Configuration write channel
interface bed_cfg_if import bed_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/binary_erode_dilate.sv -----
// Binary erosion / dilation over a stored mask frame. A write item stores one
// mask bit at (pos_x, pos_y); a read item returns the bit filtered by a square
// window of half size window_radius (erosion: all in-frame and set; dilation:
// any in-frame pixel set). Positions outside the configured frame give
// coordinate_error = 1 and filtered_bit = 0, and such writes are dropped.
// The store powers up with unknown contents and has no clearing pass: every
// pixel a read window touches must have been written first. An in-frame read
// walks the window through the store's single read port, which yields one
// window pixel per cycle; writes and out-of-frame items need no walk. The next
// item is accepted while a result still waits in the output register.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this, and ready on the configuration port is
// always high.
module binary_erode_dilate import bed_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bed_in_if.sink    in_i,
  bed_out_if.source out_o,
  bed_cfg_if.sink   cfg_i
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration registers
  logic [CFG_DIM_W-1:0] img_w_q, img_h_q;
  logic [CFG_RAD_W-1:0] window_radius_q;
  logic                 filter_mode_q;

  logic [CFG_DIM_W-1:0] w_eff, h_eff;
  logic [CFG_RAD_W-1:0] r_eff;

  state_e state_q, state_d;

  logic             in_fire, in_inside, scan_start, ram_we, load_out;
  logic [POS_W-1:0] x_q, y_q;
  logic             acc_q, err_q;
  logic             out_valid_q, out_bit_q, out_err_q;

  logic             ram_re, ram_rdata;
  logic [AddrW-1:0] ram_raddr, ram_waddr;
  probe_t           probe;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q         <= CFG_DIM_W'(256);
      img_h_q         <= CFG_DIM_W'(256);
      window_radius_q <= CFG_RAD_W'(1);
      filter_mode_q   <= MODE_ERODE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH:   img_w_q         <= cfg_i.data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:  img_h_q         <= cfg_i.data[CFG_DIM_W-1:0];
        REG_WINDOW_RADIUS: window_radius_q <= cfg_i.data[CFG_RAD_W-1:0];
        REG_FILTER_MODE:   filter_mode_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Saturate frame size and radius to what the store was built for
  assign w_eff = (int'(img_w_q) > MAX_WIDTH) ? CFG_DIM_W'(MAX_WIDTH) : img_w_q;
  assign h_eff = (int'(img_h_q) > MAX_HEIGHT) ? CFG_DIM_W'(MAX_HEIGHT)
                                               : img_h_q;
  assign r_eff = (int'(window_radius_q) > MAX_RADIUS) ? CFG_RAD_W'(MAX_RADIUS)
                                                       : window_radius_q;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_inside = ({1'b0, in_i.pos_x} < w_eff) && ({1'b0, in_i.pos_y} < h_eff);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.command == CMD_READ && in_inside) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (probe.valid && probe.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_SCAN: ;
      ST_DONE: load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign scan_start = in_fire && (in_i.command == CMD_READ) && in_inside;
  assign ram_we     = in_fire && (in_i.command == CMD_WRITE) && in_inside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item capture and window accumulator (AND for erosion, OR for dilation)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= in_i.pos_x;
      y_q   <= in_i.pos_y;
      err_q <= !in_inside;
      acc_q <= scan_start ? (filter_mode_q == MODE_ERODE) : 1'b0;
    end else if (probe.valid) begin
      if (filter_mode_q == MODE_DILATE) begin
        acc_q <= acc_q | (probe.in_frame & ram_rdata);
      end else begin
        acc_q <= acc_q & (probe.in_frame & ram_rdata);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_bit_q <= acc_q;
      out_err_q <= err_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.filtered_bit     = out_bit_q;
  assign out_o.coordinate_error = out_err_q;

  assign ram_waddr = AddrW'(in_i.pos_y) * AddrW'(MAX_WIDTH) + AddrW'(in_i.pos_x);

  bed_win #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (AddrW)
  ) u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .radius_i (r_eff),
    .cx_i     (x_q),
    .cy_i     (y_q),
    .width_i  (w_eff),
    .height_i (h_eff),
    .re_o     (ram_re),
    .addr_o   (ram_raddr),
    .probe_o  (probe)
  );

  bed_ram #(
    .WIDTH (1),
    .DEPTH (Depth)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.pixel_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_probe_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe.valid |-> (state_q == ST_SCAN))
    else $error("window probe outside of a scan");

  a_read_scans : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |=> (state_q == ST_SCAN))
    else $error("in-frame read did not start a scan");

  a_result_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_o.ready) |=>
      (state_q == ST_DONE && $stable(out_bit_q) && $stable(out_err_q)))
    else $error("pending result overwritten");

  a_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE && in_inside))
    else $error("store write outside frame or while busy");

endmodule

// ----- design/bed_ram.sv -----
module bed_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bed_win.sv -----
module bed_win import bed_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int ADDR_W    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CFG_RAD_W-1:0] radius_i,
  input  logic [POS_W-1:0]     cx_i,
  input  logic [POS_W-1:0]     cy_i,
  input  logic [CFG_DIM_W-1:0] width_i,
  input  logic [CFG_DIM_W-1:0] height_i,
  output logic                 re_o,
  output logic [ADDR_W-1:0]    addr_o,
  output probe_t               probe_o
);

  logic                      active_q;
  logic signed [OFS_W-1:0]   dx_q, dy_q;
  logic signed [OFS_W-1:0]   rad_s;
  logic                      last_x, last_y;
  logic signed [COORD_W-1:0] xx, yy;
  logic                      in_frame;
  probe_t                    probe_q;

  assign rad_s  = $signed({1'b0, radius_i});
  assign last_x = (dx_q == rad_s);
  assign last_y = (dy_q == rad_s);

  // Raster walk over the window, row by row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dx_q     <= '0;
      dy_q     <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      dx_q     <= -rad_s;
      dy_q     <= -rad_s;
    end else if (active_q) begin
      if (last_x) begin
        dx_q <= -rad_s;
        if (last_y) begin
          active_q <= 1'b0;
        end else begin
          dy_q <= dy_q + OFS_W'(1);
        end
      end else begin
        dx_q <= dx_q + OFS_W'(1);
      end
    end
  end

  // Window pixel position and frame check
  assign xx = $signed({{(COORD_W-POS_W){1'b0}}, cx_i}) + COORD_W'(dx_q);
  assign yy = $signed({{(COORD_W-POS_W){1'b0}}, cy_i}) + COORD_W'(dy_q);

  assign in_frame = !xx[COORD_W-1] && !yy[COORD_W-1] &&
                    (xx[CFG_DIM_W-1:0] < width_i) && (yy[CFG_DIM_W-1:0] < height_i);

  // Store address, row-major with a fixed row pitch
  assign addr_o = ADDR_W'(yy[CFG_DIM_W-1:0]) * ADDR_W'(MAX_WIDTH)
                + ADDR_W'(xx[CFG_DIM_W-1:0]);
  assign re_o   = active_q;

  // Probe tag delayed to line up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q.valid    <= active_q;
      probe_q.in_frame <= in_frame;
      probe_q.last     <= active_q && last_x && last_y;
    end
  end

  assign probe_o = probe_q;

  a_last_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !start_i && last_x && last_y) |=> !active_q)
    else $error("window walk continued past its last pixel");

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !active_q)
    else $error("window walk restarted while running");

  a_last_tagged : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !start_i && last_x && last_y) |=> (probe_o.valid && probe_o.last))
    else $error("last probe not tagged");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bed_pkg::*;

  localparam int STRIDE = DEF_MAX_WIDTH;

  // Expected result of one item
  typedef struct packed {
    logic filtered;
    logic coord_err;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bed_in_if  in_if ();
  bed_out_if out_if ();
  bed_cfg_if cfg_if ();

  binary_erode_dilate uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block's registers and mask store
  logic [CFG_DIM_W-1:0] cur_width  = 9'd256;
  logic [CFG_DIM_W-1:0] cur_height = 9'd256;
  logic [CFG_RAD_W-1:0] cur_radius = 3'd1;
  logic                 cur_mode   = MODE_ERODE;
  bit mask_mem   [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  bit mask_known [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];

  result_t pending_results [$];
  result_t want;

  int err_count    = 0;
  int n_items      = 0;
  int n_reads      = 0;
  int n_off_frame  = 0;
  int n_checked    = 0;
  int n_settings   = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_left    = 0;
  int one_density  = 50;

  function automatic int eff_width();
    return (cur_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cur_width);
  endfunction

  function automatic int eff_height();
    return (cur_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(cur_height);
  endfunction

  // Square-window erosion / dilation of the mirrored mask
  function automatic logic window_filter(int x, int y);
    int  w, h, r, xx, yy, dx, dy;
    bit  in_frame, px_set;
    w = eff_width();
    h = eff_height();
    r = int'(cur_radius);
    if (r == 0) return mask_mem[y*STRIDE + x];
    for (dy = -r; dy <= r; dy++) begin
      for (dx = -r; dx <= r; dx++) begin
        xx = x + dx;
        yy = y + dy;
        in_frame = xx >= 0 && yy >= 0 && xx < w && yy < h;
        px_set = in_frame && mask_mem[yy*STRIDE + xx];
        if (cur_mode == MODE_DILATE && px_set) return 1'b1;
        if (cur_mode == MODE_ERODE && !px_set) return 1'b0;
      end
    end
    return (cur_mode == MODE_DILATE) ? 1'b0 : 1'b1;
  endfunction

  // Result of one accepted item; writes update the mirrored store
  function automatic result_t predict_item(logic cmd, int x, int y, logic pix);
    result_t res;
    bit      in_frame;
    in_frame = x < eff_width() && y < eff_height();
    res.filtered  = 1'b0;
    res.coord_err = !in_frame;
    if (in_frame) begin
      if (cmd == CMD_WRITE) begin
        mask_mem[y*STRIDE + x]   = pix;
        mask_known[y*STRIDE + x] = 1'b1;
      end else begin
        res.filtered = window_filter(x, y);
      end
    end
    return res;
  endfunction

  // Result checker: each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected: filtered_bit %0b coordinate_error %0b",
                 $time, out_if.filtered_bit, out_if.coordinate_error);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_if.filtered_bit !== want.filtered) begin
          err_count++;
          $display("%0t: filtered_bit mismatch: expected %0b actual %0b",
                   $time, want.filtered, out_if.filtered_bit);
        end
        if (out_if.coordinate_error !== want.coord_err) begin
          err_count++;
          $display("%0t: coordinate_error mismatch: expected %0b actual %0b",
                   $time, want.coord_err, out_if.coordinate_error);
        end
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic set_idle(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // Offer one item; it is predicted at the edge where it is accepted
  task automatic send_item(input logic cmd, input int x, input int y, input logic pix);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.pos_x    <= x[POS_W-1:0];
    in_if.pos_y    <= y[POS_W-1:0];
    in_if.pixel_in <= pix;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_item(cmd, x, y, pix));
    n_items++;
    if (!(x < eff_width() && y < eff_height())) n_off_frame++;
    else if (cmd == CMD_READ) n_reads++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:   cur_width  = val[CFG_DIM_W-1:0];
      REG_FRAME_HEIGHT:  cur_height = val[CFG_DIM_W-1:0];
      REG_WINDOW_RADIUS: cur_radius = val[CFG_RAD_W-1:0];
      REG_FILTER_MODE:   cur_mode   = val[0];
      default: ;
    endcase
  endtask

  // All four registers, written only once the block has gone quiet
  task automatic set_config(input int w, input int h, input int r, input logic mode);
    wait_drain();
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    write_register(REG_WINDOW_RADIUS, r);
    write_register(REG_FILTER_MODE, int'(mode));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic pick_bit();
    return ($urandom_range(99) < one_density);
  endfunction

  // Write every in-frame window pixel not yet defined, so reads stay legal
  task automatic fill_window(input int x, input int y);
    int r, dx, dy, xx, yy;
    r = int'(cur_radius);
    for (dy = -r; dy <= r; dy++) begin
      for (dx = -r; dx <= r; dx++) begin
        xx = x + dx;
        yy = y + dy;
        if (xx >= 0 && yy >= 0 && xx < eff_width() && yy < eff_height() &&
            !mask_known[yy*STRIDE + xx])
          send_item(CMD_WRITE, xx, yy, pick_bit());
      end
    end
  endtask

  task automatic filtered_read(input int x, input int y);
    fill_window(x, y);
    send_item(CMD_READ, x, y, 1'($urandom_range(1)));
  endtask

  task automatic send_off_frame();
    int x, y, ew, eh;
    ew = eff_width();
    eh = eff_height();
    x = $urandom_range(255);
    y = $urandom_range(255);
    if (ew > 0 && eh > 0) begin
      if (ew < DEF_MAX_WIDTH && (eh == DEF_MAX_HEIGHT || $urandom_range(1)))
        x = $urandom_range(255, ew);
      else
        y = $urandom_range(255, eh);
    end
    send_item(1'($urandom_range(1)), x, y, 1'($urandom_range(1)));
  endtask

  // Anchor of the working patch: low edge, high edge or anywhere
  function automatic int pick_anchor(int extent, int span);
    case ($urandom_range(2))
      0:       return 0;
      1:       return extent - span;
      default: return $urandom_range(extent - span);
    endcase
  endfunction

  // One register setting with random writes, reads and off-frame noise
  task automatic run_phase(input int w, input int h, input int r, input logic mode,
                           input int budget, input int density);
    int ew, eh, sx, sy, x0, y0, stop_at, x, y, sel;
    set_config(w, h, r, mode);
    one_density = density;
    ew = eff_width();
    eh = eff_height();
    sx = (ew < 12) ? ew : 12;
    sy = (eh < 12) ? eh : 12;
    x0 = pick_anchor(ew, sx);
    y0 = pick_anchor(eh, sy);
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      sel = $urandom_range(99);
      if (ew == 0 || eh == 0 ||
          (sel < 15 && (ew < DEF_MAX_WIDTH || eh < DEF_MAX_HEIGHT))) begin
        send_off_frame();
      end else begin
        x = x0 + $urandom_range(sx - 1);
        y = y0 + $urandom_range(sy - 1);
        if (sel < 45) send_item(CMD_WRITE, x, y, pick_bit());
        else          filtered_read(x, y);
      end
    end
  endtask

  // Reset settings: erosion with radius 1 at the far corner, then dilation
  task automatic test_default_corner();
    send_item(CMD_WRITE, 255, 255, 1'b1);
    send_item(CMD_WRITE, 254, 255, 1'b1);
    send_item(CMD_WRITE, 255, 254, 1'b1);
    send_item(CMD_WRITE, 254, 254, 1'b1);
    send_item(CMD_READ, 255, 255, 1'b0);
    set_config(256, 256, 1, MODE_DILATE);
    send_item(CMD_READ, 255, 255, 1'b1);
  endtask

  // 3x3 frame: full window inside, window past the edge, off-frame items
  task automatic test_small_frame();
    int x, y;
    set_config(3, 3, 1, MODE_ERODE);
    for (y = 0; y < 3; y++)
      for (x = 0; x < 3; x++)
        send_item(CMD_WRITE, x, y, 1'b1);
    send_item(CMD_READ, 1, 1, 1'b0);
    send_item(CMD_READ, 0, 0, 1'b0);
    send_item(CMD_WRITE, 3, 0, 1'b1);
    send_item(CMD_READ, 0, 3, 1'b0);
  endtask

  // Radius 0 passes the stored bit through
  task automatic test_radius_zero();
    set_config(3, 3, 0, MODE_DILATE);
    send_item(CMD_WRITE, 2, 2, 1'b0);
    send_item(CMD_READ, 2, 2, 1'b0);
  endtask

  // Zero width: every position is off frame
  task automatic test_empty_frame();
    set_config(0, 3, 1, MODE_ERODE);
    send_item(CMD_READ, 0, 0, 1'b0);
    send_item(CMD_WRITE, 0, 0, 1'b1);
  endtask

  // Width beyond the store saturates, so column 255 stays in frame
  task automatic test_oversize_frame();
    set_config(400, 1, 0, MODE_ERODE);
    send_item(CMD_WRITE, 255, 0, 1'b1);
    send_item(CMD_READ, 255, 0, 1'b0);
  endtask

  // Receiver holds off for a long stretch so the block backs up
  task automatic test_backpressure();
    int k;
    set_idle(0, 0);
    set_config(16, 4, 0, MODE_DILATE);
    hold_left = 300;
    for (k = 0; k < 40; k++) begin
      if (k < 24) send_item(CMD_WRITE, $urandom_range(15), $urandom_range(3),
                            1'($urandom_range(1)));
      else        filtered_read($urandom_range(15), $urandom_range(3));
    end
  endtask

  task automatic test_random_items();
    set_idle(34, 83);
    run_phase(8, 8, 1, MODE_ERODE, 80, 85);
    run_phase(1, 1, 7, MODE_DILATE, 40, 50);
    run_phase(256, 256, 7, MODE_ERODE, 80, 99);
    set_idle(83, 34);
    run_phase($urandom_range(24, 2), $urandom_range(24, 2), $urandom_range(7),
              MODE_DILATE, 80, 15);
    run_phase(1, 256, 3, MODE_ERODE, 60, 90);
    run_phase(256, 1, 2, MODE_DILATE, 60, 20);
    set_idle(0, 0);
    run_phase($urandom_range(40, 1), $urandom_range(40, 1), 0, 1'($urandom_range(1)),
              60, 50);
    run_phase($urandom_range(256, 1), $urandom_range(256, 1), $urandom_range(7),
              1'($urandom_range(1)), 80, $urandom_range(90, 10));
    run_phase(300, 511, 5, MODE_ERODE, 80, 99);
  endtask

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_WRITE;
    in_if.pos_x     = '0;
    in_if.pos_y     = '0;
    in_if.pixel_in  = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_FRAME_WIDTH;
    cfg_if.data     = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_corner();
    test_small_frame();
    test_radius_zero();
    test_empty_frame();
    test_oversize_frame();
    test_backpressure();
    test_random_items();

    wait_drain();
    repeat (240) @(posedge clk_i);
    $display("Covered %0d items: %0d filtered reads, %0d off-frame, %0d results checked",
             n_items, n_reads, n_off_frame, n_checked);
    $display("Register settings applied: %0d (erosion and dilation, radius 0..7)",
             n_settings);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- binary_erode_dilate.f -----
design/bed_pkg.sv
design/bed_if.sv
design/bed_ram.sv
design/bed_win.sv
design/binary_erode_dilate.sv
tb/testbench.sv
